// ===== sv/tsfrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfrf_pkg
// Shared types and constants for the short-form tlv record finder.
// ----------------------------------------------------------------------------
package tsfrf_pkg;

    // configuration register indexes
    localparam logic CFG_TARGET_TAG = 1'b0;
    localparam logic CFG_LIST_ALL   = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // buffer status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_BAD     = 2'd2;

    // result queue geometry
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int FIFO_CW    = FIFO_AW + 1;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] record_tag;
        logic [6:0] record_length;
        logic [7:0] value_byte;
        logic [1:0] status;
        logic       last_of_run;
    } t_result;

    // results caused by one request, oldest in first
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_run;

endpackage

// ===== sv/tsfrf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfrf_parser
// Per-buffer parse state and the single-pass result logic for one byte.
// ----------------------------------------------------------------------------
module tsfrf_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_data_byte,
    input  logic               i_final_byte,
    input  logic               i_empty_buffer,
    input  logic [7:0]         i_target_tag,
    input  logic               i_list_all_records,
    output tsfrf_pkg::t_run    o_run
);

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_tag, n_tag;
    logic [6:0] r_rem, n_rem;
    logic       r_sel, n_sel;
    logic       r_found, n_found;
    logic       r_err, n_err;

    logic                have_data, have_stat, sel_now;
    tsfrf_pkg::t_result  data_res, stat_res;

    // next state and results for the byte in the input register
    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_rem    = r_rem;
        n_sel    = r_sel;
        n_found  = r_found;
        n_err    = r_err;
        have_data = 1'b0;
        sel_now   = 1'b0;
        data_res  = '0;
        stat_res  = '0;

        if (!i_empty_buffer) begin
            unique case (r_phase)
                PH_TAG: begin
                    n_tag   = i_data_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (i_data_byte[7]) begin
                        // long-form length
                        n_err   = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        sel_now = i_list_all_records || (r_tag == i_target_tag);
                        n_rem   = i_data_byte[6:0];
                        n_sel   = sel_now;
                        if (sel_now) begin
                            have_data              = 1'b1;
                            data_res.kind          = tsfrf_pkg::KIND_HEADER;
                            data_res.record_tag    = r_tag;
                            data_res.record_length = i_data_byte[6:0];
                        end
                        if (i_data_byte[6:0] == 7'd0) begin
                            // zero-length record completes here
                            if (sel_now && !i_list_all_records) begin
                                n_found = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_TAG;
                            end
                            n_sel = 1'b0;
                        end else begin
                            n_phase = PH_VAL;
                        end
                    end
                end
                PH_VAL: begin
                    if (r_sel) begin
                        have_data           = 1'b1;
                        data_res.kind       = tsfrf_pkg::KIND_VALUE;
                        data_res.record_tag = r_tag;
                        data_res.value_byte = i_data_byte;
                    end
                    n_rem = r_rem - 7'd1;
                    if (n_rem == 7'd0) begin
                        if (r_sel && !i_list_all_records) begin
                            n_found = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_TAG;
                        end
                        n_sel = 1'b0;
                    end
                end
                PH_DONE: begin
                    // ignore bytes until the buffer ends
                end
                default: begin
                end
            endcase
        end

        // buffer end: status, then per-buffer state is cleared
        have_stat     = i_final_byte || i_empty_buffer;
        stat_res.kind = tsfrf_pkg::KIND_STATUS;
        stat_res.last_of_run = 1'b1;
        priority if (n_err || (n_phase == PH_VAL && n_rem != 7'd0)) begin
            stat_res.status = tsfrf_pkg::STAT_BAD;
        end else if (i_list_all_records) begin
            stat_res.status = tsfrf_pkg::STAT_OK;
        end else if (n_found) begin
            stat_res.status = tsfrf_pkg::STAT_OK;
        end else begin
            stat_res.status = tsfrf_pkg::STAT_MISSING;
        end
        if (have_stat) begin
            n_phase = PH_TAG;
            n_tag   = '0;
            n_rem   = '0;
            n_sel   = 1'b0;
            n_found = 1'b0;
            n_err   = 1'b0;
        end
        data_res.last_of_run = !have_stat;
    end

    // pack the run for the result queue
    always_comb begin
        o_run.count  = {1'b0, have_data} + {1'b0, have_stat};
        o_run.first  = have_data ? data_res : stat_res;
        o_run.second = stat_res;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_tag   <= '0;
            r_rem   <= '0;
            r_sel   <= 1'b0;
            r_found <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_rem   <= n_rem;
            r_sel   <= n_sel;
            r_found <= n_found;
            r_err   <= n_err;
        end
    end

endmodule

// ===== sv/tsfrf_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfrf_out_fifo
// Small result queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module tsfrf_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  tsfrf_pkg::t_run               i_run,
    input  logic                          i_pop,
    output logic                          o_valid,
    output logic                          o_room2,
    output logic [tsfrf_pkg::FIFO_CW-1:0] o_count,
    output tsfrf_pkg::t_result            o_head
);

    tsfrf_pkg::t_result                 r_mem [tsfrf_pkg::FIFO_DEPTH];
    logic [tsfrf_pkg::FIFO_AW-1:0]      r_wp, r_rp, n_wp, n_rp;
    logic [tsfrf_pkg::FIFO_CW-1:0]      r_cnt, n_cnt, push_n, pop_n;
    logic [tsfrf_pkg::FIFO_AW-1:0]      wp1;

    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= tsfrf_pkg::FIFO_CW'(tsfrf_pkg::FIFO_DEPTH - 2));
    assign o_count = r_cnt;
    assign o_head  = r_mem[r_rp];
    assign wp1     = r_wp + tsfrf_pkg::FIFO_AW'(1);

    // pointer and fill arithmetic
    always_comb begin
        push_n = i_push ? tsfrf_pkg::FIFO_CW'(i_run.count) : '0;
        pop_n  = (i_pop && o_valid) ? tsfrf_pkg::FIFO_CW'(1) : '0;
        n_wp   = r_wp + push_n[tsfrf_pkg::FIFO_AW-1:0];
        n_rp   = r_rp + pop_n[tsfrf_pkg::FIFO_AW-1:0];
        n_cnt  = r_cnt + push_n - pop_n;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && i_run.count != 2'd0) begin
            r_mem[r_wp] <= i_run.first;
        end
        if (i_push && i_run.count == 2'd2) begin
            r_mem[wp1] <= i_run.second;
        end
    end

endmodule

// ===== sv/tlv_short_form_record_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_short_form_record_finder
// Parses short-form tag/length/value records from a byte stream and
// delivers the matching record (find mode) or every record (list mode).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one buffer byte per request,
//   with i_final_byte on the last byte or i_empty_buffer for a zero-length
//   buffer. Output channel (o_out_valid / i_out_ready) gives record headers,
//   value bytes and one status per buffer; o_last_of_run closes the results
//   of one input byte. A status of bad record means the results delivered
//   for the buffer must be dropped.
//   Configuration (i_cfg_we, i_cfg_index, i_cfg_data) must be written while
//   idle (not enforced): index 0 is the target tag, index 1 selects list mode.
// Path: an accepted byte waits in the input register, then the parse logic
//   writes its results into the result queue that drives the output.
// Throughput: one byte per cycle while each byte yields at most one result
//   and no output stall; two results of one byte share the single output port.
// Reset: parse state, configuration and the four-entry result queue are
//   cleared. On an output stall the queue fills and o_in_ready drops once
//   fewer than two entries are free and the input register is occupied.
// ----------------------------------------------------------------------------
module tlv_short_form_record_finder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    input  logic       i_empty_buffer,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_record_tag,
    output logic [6:0] o_record_length,
    output logic [7:0] o_value_byte,
    output logic [1:0] o_status,
    output logic       o_last_of_run,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_target_tag;
    logic       r_list_all;
    logic       r_in_vld;
    logic [7:0] r_data;
    logic       r_fin, r_emp;
    logic       fire, room2;

    tsfrf_pkg::t_run                  run;
    tsfrf_pkg::t_result               head;
    logic [tsfrf_pkg::FIFO_CW-1:0]    fifo_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_tag <= '0;
            r_list_all   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsfrf_pkg::CFG_TARGET_TAG: r_target_tag <= i_cfg_data;
                tsfrf_pkg::CFG_LIST_ALL:   r_list_all   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    assign fire       = r_in_vld && room2;
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_data_byte;
            r_fin  <= i_final_byte;
            r_emp  <= i_empty_buffer;
        end
    end

    // parse logic
    tsfrf_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_data_byte        (r_data),
        .i_final_byte       (r_fin),
        .i_empty_buffer     (r_emp),
        .i_target_tag       (r_target_tag),
        .i_list_all_records (r_list_all),
        .o_run              (run)
    );

    // result queue
    tsfrf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_run   (run),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_room2 (room2),
        .o_count (fifo_count),
        .o_head  (head)
    );

    assign o_kind          = head.kind;
    assign o_record_tag    = head.record_tag;
    assign o_record_length = head.record_length;
    assign o_value_byte    = head.value_byte;
    assign o_status        = head.status;
    assign o_last_of_run   = head.last_of_run;

    // queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= tsfrf_pkg::FIFO_CW'(tsfrf_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // a status result always closes its run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == tsfrf_pkg::KIND_STATUS) |-> o_last_of_run)
        else $error("status result without last_of_run");

    // a held byte stays until the parser takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !fire) |=> (r_in_vld && $stable(r_data)))
        else $error("input register lost a request");

endmodule
